FILE: rtl/bdq_pkg.sv
// Package for the bounded deque: sizes, codes, beat types and word helpers.
`default_nettype none

package bdq_pkg;

    // Storage size and stored word width
    localparam int DEPTH      = 16;
    localparam int DATA_WIDTH = 32;

    // Derived widths
    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    // Request codes
    typedef enum logic [1:0] {
        FN_PUSH_FRONT   = 2'd0,
        FN_PUSH_BACK    = 2'd1,
        FN_REMOVE_FRONT = 2'd2,
        FN_REMOVE_BACK  = 2'd3
    } t_bdq_func;

    // Result status codes
    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } t_bdq_status;

    typedef logic [PTR_W-1:0]      t_ptr;
    typedef logic [CNT_W-1:0]      t_cnt;
    typedef logic [DATA_WIDTH-1:0] t_word;

    // Request beat
    typedef struct packed {
        t_bdq_func          func;
        logic signed [31:0] value;
    } t_bdq_in;

    // Result beat
    typedef struct packed {
        logic signed [31:0] taken_value;
        logic signed [31:0] front_value;
        t_bdq_status        status;
        logic [4:0]         count;
    } t_bdq_out;

    // Advance a ring pointer
    function automatic t_ptr ptr_inc(input t_ptr p);
        return (p == PTR_W'(DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    // Step a ring pointer back
    function automatic t_ptr ptr_dec(input t_ptr p);
        return (p == '0) ? PTR_W'(DEPTH - 1) : p - 1'b1;
    endfunction

    // Fit a request word into the stored width
    function automatic t_word to_word(input logic signed [31:0] v);
        return DATA_WIDTH'(v);
    endfunction

    // Sign-extend a stored word to the 32-bit result field
    function automatic logic signed [31:0] word_out(input t_word d);
        logic signed [DATA_WIDTH-1:0] s;
        s = d;
        return 32'(s);
    endfunction

endpackage

`default_nettype wire

FILE: rtl/bdq_ram.sv
// Generic RAM: one write port, two read ports with registered read data.
`default_nettype none

module bdq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr_a,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr_b,
    output logic      [WIDTH-1:0]         o_rdata_a,
    output logic      [WIDTH-1:0]         o_rdata_b
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata_a;
    logic [WIDTH-1:0] r_rdata_b;

    // Write one entry, read two
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata_a <= r_mem[i_raddr_a];
        r_rdata_b <= r_mem[i_raddr_b];
    end

    assign o_rdata_a = r_rdata_a;
    assign o_rdata_b = r_rdata_b;

endmodule

`default_nettype wire

FILE: rtl/bounded_deque_core.sv
// Bounded double-ended queue of signed words held in a ring buffer RAM.
// Usage:
//   A request beat on i_in_data (func, value) is taken when i_in_valid and
//   o_in_ready are both high. func pushes at the front or back, or removes
//   from the front or back. Every request gives exactly one result beat on
//   o_out_data: the removed word, the front word after the step, a status
//   (ok, removal from empty, push into full) and the new count.
//   A refused request leaves the queue unchanged.
// Timing:
//   The request addresses the RAM in its accept cycle; the registered read
//   data comes back in the next cycle, where the entry is modified, written
//   back and the result loaded into the output register. The block takes a
//   new request only after the current one leaves execute, since the RAM
//   read data is registered before the write-back.
// Reset:
//   i_rst_n (synchronous, active low) empties the queue; no clearing pass.
// Stall:
//   If the receiver holds i_out_ready low, the finished result waits in the
//   output register and the next request is still taken; its own result
//   then waits in the execute cycle until the output register frees up.
`default_nettype none

module bounded_deque_core
    import bdq_pkg::*;
(
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_in_valid,
    output logic          o_in_ready,
    input  wire t_bdq_in  i_in_data,
    output logic          o_out_valid,
    input  wire logic     i_out_ready,
    output t_bdq_out      o_out_data
);

    typedef enum logic {
        S_IDLE,
        S_EXEC
    } t_state;

    t_state    r_state;
    t_ptr      r_front;
    t_ptr      r_back;
    t_cnt      r_count;
    t_bdq_func r_func;
    t_word     r_word;
    t_ptr      r_addr_a;
    t_ptr      r_addr_b;
    logic      r_out_valid;
    t_bdq_out  r_out_data;

    t_ptr      n_front;
    t_ptr      n_back;
    t_cnt      n_count;
    t_bdq_out  n_out_data;
    t_ptr      rd_addr_a;
    t_ptr      rd_addr_b;
    logic      wr_en;
    t_ptr      wr_addr;
    t_word     rd_data_a;
    t_word     rd_data_b;
    logic      accept;
    logic      out_free;
    logic      finish;
    logic      is_full;
    logic      is_empty;
    t_cnt      cnt_dec;

    assign accept   = i_in_valid && o_in_ready;
    assign out_free = !r_out_valid || i_out_ready;
    assign finish   = (r_state == S_EXEC) && out_free;
    assign is_full  = (r_count == CNT_W'(DEPTH));
    assign is_empty = (r_count == '0);
    assign cnt_dec  = r_count - 1'b1;

    // Pick read addresses on accept, hold them while executing
    always_comb begin
        rd_addr_a = r_addr_a;
        rd_addr_b = r_addr_b;
        if (r_state == S_IDLE) begin
            rd_addr_a = (i_in_data.func == FN_REMOVE_BACK) ? ptr_dec(r_back) : r_front;
            rd_addr_b = (i_in_data.func == FN_REMOVE_FRONT) ? ptr_inc(r_front) : r_front;
        end
    end

    // Modify: next pointers, count, write-back and result
    always_comb begin
        n_front                = r_front;
        n_back                 = r_back;
        n_count                = r_count;
        wr_en                  = 1'b0;
        wr_addr                = r_back;
        n_out_data.taken_value = '0;
        n_out_data.front_value = is_empty ? '0 : word_out(rd_data_b);
        n_out_data.status      = ST_OK;
        unique case (r_func)
            FN_PUSH_FRONT: begin
                if (is_full) begin
                    n_out_data.status = ST_FULL;
                end else begin
                    n_front                = ptr_dec(r_front);
                    wr_en                  = 1'b1;
                    wr_addr                = ptr_dec(r_front);
                    n_count                = r_count + 1'b1;
                    n_out_data.front_value = word_out(r_word);
                end
            end
            FN_PUSH_BACK: begin
                if (is_full) begin
                    n_out_data.status = ST_FULL;
                end else begin
                    n_back  = ptr_inc(r_back);
                    wr_en   = 1'b1;
                    wr_addr = r_back;
                    n_count = r_count + 1'b1;
                    if (is_empty) begin
                        n_out_data.front_value = word_out(r_word);
                    end
                end
            end
            FN_REMOVE_FRONT: begin
                if (is_empty) begin
                    n_out_data.status = ST_EMPTY;
                end else begin
                    n_front                = ptr_inc(r_front);
                    n_count                = cnt_dec;
                    n_out_data.taken_value = word_out(rd_data_a);
                    n_out_data.front_value = (cnt_dec == '0) ? '0 : word_out(rd_data_b);
                end
            end
            FN_REMOVE_BACK: begin
                if (is_empty) begin
                    n_out_data.status = ST_EMPTY;
                end else begin
                    n_back                 = ptr_dec(r_back);
                    n_count                = cnt_dec;
                    n_out_data.taken_value = word_out(rd_data_a);
                    n_out_data.front_value = (cnt_dec == '0) ? '0 : word_out(rd_data_b);
                end
            end
            default: begin
                n_out_data.status = ST_OK;
            end
        endcase
        n_out_data.count = 5'(n_count);
    end

    // Ring buffer storage
    bdq_ram #(
        .WIDTH (DATA_WIDTH),
        .DEPTH (DEPTH)
    ) u_ram (
        .i_clk     (i_clk),
        .i_we      (wr_en && finish),
        .i_waddr   (wr_addr),
        .i_wdata   (r_word),
        .i_raddr_a (rd_addr_a),
        .i_raddr_b (rd_addr_b),
        .o_rdata_a (rd_data_a),
        .o_rdata_b (rd_data_b)
    );

    // Sequencer, queue state and result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_front     <= '0;
            r_back      <= '0;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_addr_a <= rd_addr_a;
            r_addr_b <= rd_addr_b;
            if (finish) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        r_func  <= i_in_data.func;
                        r_word  <= to_word(i_in_data.value);
                        r_state <= S_EXEC;
                    end
                end
                S_EXEC: begin
                    if (out_free) begin
                        r_front     <= n_front;
                        r_back      <= n_back;
                        r_count     <= n_count;
                        r_out_data  <= n_out_data;
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

    // Occupancy never exceeds the ring size
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(DEPTH))
        else $error("deque count above depth");

    // Empty or full ring has coinciding pointers
    a_ptr_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count == '0 || r_count == CNT_W'(DEPTH)) |-> (r_front == r_back))
        else $error("deque pointers disagree with count");

    // An accepted request blocks further requests in the next cycle
    a_accept_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> (r_state == S_EXEC))
        else $error("accepted request did not enter execute");

    // A refused removal reports an empty queue
    a_empty_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (finish && n_out_data.status == ST_EMPTY) |=> (r_count == '0))
        else $error("empty status with stored words");

    // The write-back never happens outside execute
    a_write_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> !(wr_en && finish))
        else $error("RAM write while idle");

endmodule

`default_nettype wire
